>>> src/stt_pkg.sv
// Package for the software timer task table: field widths, result and item
// codes, sequencer states and the layout of one table entry.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package stt_pkg;

	localparam int unsigned DEFAULT_TABLE_DEPTH = 16;

	localparam int unsigned TIME_W     = 32;
	localparam int unsigned INTERVAL_W = 16;
	localparam int unsigned TAG_W      = 8;
	localparam int unsigned RKIND_W    = 2;

	typedef enum logic {
		KIND_CREATE = 1'b0,
		KIND_TICK   = 1'b1
	} item_kind_t;

	typedef enum logic [RKIND_W-1:0] {
		RES_ACK   = 2'd0,
		RES_FIRED = 2'd1,
		RES_DONE  = 2'd2
	} result_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CREATE,
		ST_READ,
		ST_EVAL,
		ST_DONE
	} state_t;

	// A deadline of zero marks a free slot.
	typedef struct packed {
		logic [TIME_W-1:0]     deadline;
		logic [INTERVAL_W-1:0] period;
		logic                  repeat_flag;
		logic [TAG_W-1:0]      tag;
	} entry_t;

endpackage

`default_nettype wire

>>> src/stt_if.sv
// Channel interfaces of the software timer task table: the command channel
// that carries create and tick items, and the response channel.
// Depends on stt_pkg for the field widths.
`default_nettype none

interface stt_cmd_if;
	import stt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [TIME_W-1:0]     now_ms;
	logic [INTERVAL_W-1:0] interval_ms;
	logic                  repeat_flag;
	logic [TAG_W-1:0]      task_tag;

	modport source (
		output valid, kind, now_ms, interval_ms, repeat_flag, task_tag,
		input  ready
	);

	modport sink (
		input  valid, kind, now_ms, interval_ms, repeat_flag, task_tag,
		output ready
	);
endinterface

interface stt_rsp_if #(
	parameter int unsigned SLOT_W = 5
);
	import stt_pkg::*;

	logic               valid;
	logic               ready;
	logic [RKIND_W-1:0] result_kind;
	logic [TAG_W-1:0]   fired_tag;
	logic [SLOT_W-1:0]  slot_index;
	logic               status;
	logic               last;

	modport source (
		output valid, result_kind, fired_tag, slot_index, status, last,
		input  ready
	);

	modport sink (
		input  valid, result_kind, fired_tag, slot_index, status, last,
		output ready
	);
endinterface

`default_nettype wire

>>> src/software_timer_task_table_top.sv
// Top level of the software timer task table: entry memory, sequencer and
// response register. Depends on stt_pkg and the interfaces in stt_if.sv.
`default_nettype none

// A table of up to TABLE_DEPTH software timers. A create item appends a task
// at the current live count with deadline now_ms + interval_ms (wrapping at
// 32 bits) and answers with one acknowledge transfer; when the table is full
// the create is dropped and the acknowledge carries status 1. A tick item
// walks the live slots in ascending order, produces one fired transfer for
// every task whose deadline is non-zero and at or before now_ms, re-arms
// repeating tasks at now_ms + period and frees one-shot tasks, then closes
// with a done transfer that carries the new live count. Only the final
// transfer of an item has last set. The comparison is plain unsigned, and a
// deadline that wraps to exactly zero counts as a free slot, so such a task
// vanishes at the next tick without firing. Compaction happens during the
// same walk: each surviving entry is written back to the next low slot as
// soon as it has been examined, so the order of tasks never changes. The
// block takes one item at a time. A create takes the command, then writes
// the entry and the acknowledge. A tick takes the command, then for each
// live slot does a registered read of the entry memory and a pass through
// the shared adder and the deadline comparator, then one more pass through
// the read state that finds the end of the table, then the done transfer.
// A response register that is still full holds up either kind of item.
// Reset clears only the live count and the control state; entries at or
// above the live count are never used.

module software_timer_task_table_top #(
	parameter int unsigned TABLE_DEPTH = stt_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire        clk,
	input  wire        arst_n,
	stt_cmd_if.sink    cmd,
	stt_rsp_if.source  rsp
);
	import stt_pkg::*;

	localparam int unsigned AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH + 1);

	// Sequencer state and counters.
	state_t            state_q, state_d;
	logic [SLOT_W-1:0] count_q, count_d;
	logic [SLOT_W-1:0] src_q, src_d;
	logic [SLOT_W-1:0] dst_q, dst_d;

	// Fields of the item in progress.
	logic [TIME_W-1:0]     now_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic                  rep_q;
	logic [TAG_W-1:0]      tag_q;

	// Entry memory with one write port and one registered read port.
	entry_t            entry_mem_q [TABLE_DEPTH];
	entry_t            rd_q;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	entry_t            wr_data;

	// Response register.
	logic              rsp_valid_q;
	result_kind_t      rsp_kind_q;
	logic [TAG_W-1:0]  rsp_tag_q;
	logic [SLOT_W-1:0] rsp_slot_q;
	logic              rsp_status_q;
	logic              rsp_last_q;

	logic              push;
	result_kind_t      push_kind;
	logic [TAG_W-1:0]  push_tag;
	logic [SLOT_W-1:0] push_slot;
	logic              push_status;
	logic              push_last;
	logic              can_push;

	// The one adder, shared by create and tick, and the tick's deadline comparator.
	logic [INTERVAL_W-1:0] addend;
	logic [TIME_W-1:0]     sum;
	logic                  due;
	logic                  table_full;
	logic                  keep;
	logic                  cmd_take;

	assign can_push   = !rsp_valid_q || rsp.ready;
	assign addend     = (state_q == ST_CREATE) ? interval_q : rd_q.period;
	assign sum        = now_q + {{(TIME_W-INTERVAL_W){1'b0}}, addend};
	assign due        = (rd_q.deadline != '0) && (rd_q.deadline <= now_q);
	assign table_full = (count_q == SLOT_W'(TABLE_DEPTH));
	assign cmd_take   = cmd.valid && cmd.ready;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		src_d       = src_q;
		dst_d       = dst_q;
		cmd.ready   = 1'b0;
		rd_addr     = src_q[AW-1:0];
		wr_en       = 1'b0;
		wr_addr     = dst_q[AW-1:0];
		wr_data     = rd_q;
		push        = 1'b0;
		push_kind   = RES_ACK;
		push_tag    = tag_q;
		push_slot   = count_q;
		push_status = 1'b0;
		push_last   = 1'b0;
		keep        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				src_d     = '0;
				dst_d     = '0;
				if (cmd.valid) begin
					state_d = (cmd.kind == KIND_TICK) ? ST_READ : ST_CREATE;
				end
			end
			ST_CREATE: begin
				if (can_push) begin
					push      = 1'b1;
					push_last = 1'b1;
					if (table_full) begin
						push_status = 1'b1;
					end else begin
						wr_en               = 1'b1;
						wr_addr             = count_q[AW-1:0];
						wr_data.deadline    = sum;
						wr_data.period      = interval_q;
						wr_data.repeat_flag = rep_q;
						wr_data.tag         = tag_q;
						count_d             = count_q + SLOT_W'(1);
					end
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				state_d = (src_q >= count_q) ? ST_DONE : ST_EVAL;
			end
			ST_EVAL: begin
				if (!due || can_push) begin
					if (due) begin
						push      = 1'b1;
						push_kind = RES_FIRED;
						push_tag  = rd_q.tag;
						push_slot = src_q;
						// A repeating task is re-armed; a one-shot task is freed.
						wr_data.deadline = rd_q.repeat_flag ? sum : '0;
						keep             = rd_q.repeat_flag && (sum != '0);
					end else begin
						keep = (rd_q.deadline != '0);
					end
					if (keep) begin
						wr_en = 1'b1;
						dst_d = dst_q + SLOT_W'(1);
					end
					src_d   = src_q + SLOT_W'(1);
					state_d = ST_READ;
				end
			end
			ST_DONE: begin
				if (can_push) begin
					push      = 1'b1;
					push_kind = RES_DONE;
					push_tag  = '0;
					push_slot = dst_q;
					push_last = 1'b1;
					count_d   = dst_q;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			src_q       <= '0;
			dst_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			src_q   <= src_d;
			dst_q   <= dst_d;
			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			now_q      <= cmd.now_ms;
			interval_q <= cmd.interval_ms;
			rep_q      <= cmd.repeat_flag;
			tag_q      <= cmd.task_tag;
		end
		if (push) begin
			rsp_kind_q   <= push_kind;
			rsp_tag_q    <= push_tag;
			rsp_slot_q   <= push_slot;
			rsp_status_q <= push_status;
			rsp_last_q   <= push_last;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_addr] <= wr_data;
		end
		rd_q <= entry_mem_q[rd_addr];
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.result_kind = rsp_kind_q;
	assign rsp.fired_tag   = rsp_tag_q;
	assign rsp.slot_index  = rsp_slot_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.last        = rsp_last_q;

endmodule

`default_nettype wire

>>> src/stt_checker.sv
// Port-level checks for the software timer task table, bound to the top
// level. Depends on stt_pkg for the result codes and widths.
`default_nettype none

module stt_checker #(
	parameter int unsigned SLOT_W = 5
) (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        cmd_valid,
	input wire                        cmd_ready,
	input wire                        rsp_valid,
	input wire                        rsp_ready,
	input wire [stt_pkg::RKIND_W-1:0] result_kind,
	input wire [stt_pkg::TAG_W-1:0]   fired_tag,
	input wire [SLOT_W-1:0]           slot_index,
	input wire                        status,
	input wire                        last
);
	import stt_pkg::*;

	// A response that is held back keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_kind) &&
		$stable(fired_tag) && $stable(slot_index) && $stable(status) && $stable(last))
		else $error("response changed while stalled");

	// One item at a time: after a command transfer the block is busy.
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while an item is in progress");

	// A fired result is never the final one, so the tick is still running
	// while it sits in the response register.
	a_busy_while_fired: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> !cmd_ready)
		else $error("command taken before the tick pass was done");

	// Only fired results leave last clear.
	a_last_marks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (result_kind == RES_FIRED && !last) ||
		(result_kind == RES_ACK && last) || (result_kind == RES_DONE && last))
		else $error("last flag does not match the result kind");

	// The full flag appears on acknowledges only.
	a_status_on_ack: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> result_kind == RES_ACK)
		else $error("status set on a tick result");

endmodule

bind software_timer_task_table_top stt_checker #(.SLOT_W(SLOT_W)) u_stt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.result_kind (rsp.result_kind),
	.fired_tag   (rsp.fired_tag),
	.slot_index  (rsp.slot_index),
	.status      (rsp.status),
	.last        (rsp.last)
);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the software timer task table top level.
// It depends on stt_pkg, the channel interfaces in stt_if.sv and the RTL of
// software_timer_task_table_top, and it reads nothing else.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stt_pkg::*;

	localparam int unsigned TABLE_DEPTH  = 16;
	localparam int unsigned SLOT_W       = 5;
	localparam int unsigned RANDOM_ITEMS = 350;
	// The settle wait covers a tick over a full table; the margin covers a
	// response register that is still waiting on the receiver.
	localparam int unsigned SETTLE_CYCLES = 3 + 2 * TABLE_DEPTH + 24;
	// The slowest correct gap between two transfers on either channel is a
	// full-table walk plus a sender gap plus a receiver stall; the limit is
	// set far above that.
	localparam int unsigned IDLE_LIMIT = 3000;
	localparam int unsigned PRINT_CAP  = 40;

	// One response transfer as the block should produce it.
	typedef struct packed {
		result_kind_t      kind;
		logic [TAG_W-1:0]  tag;
		logic [SLOT_W-1:0] slot;
		logic              status;
		logic              last;
	} timer_event_t;

	logic clk;
	logic arst_n;

	stt_cmd_if cmd_ch ();
	stt_rsp_if #(.SLOT_W(SLOT_W)) rsp_ch ();

	software_timer_task_table_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	// Shadow copy of the timer table. A deadline of zero marks a free slot,
	// exactly as in the block.
	logic [TIME_W-1:0]     due_ms    [TABLE_DEPTH];
	logic [INTERVAL_W-1:0] period_ms [TABLE_DEPTH];
	logic                  periodic  [TABLE_DEPTH];
	logic [TAG_W-1:0]      owner_tag [TABLE_DEPTH];
	int unsigned           tasks_live;

	// Responses owed by the block, oldest first.
	timer_event_t events_due[$];

	int unsigned mismatches;
	int unsigned items_sent;
	int unsigned burst_left;
	bit          steady_sender;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the responses of one accepted command transfer and brings the
	// shadow table up to date.
	function automatic void apply_timer_item(
		input item_kind_t            kind,
		input logic [TIME_W-1:0]     now_ms,
		input logic [INTERVAL_W-1:0] interval_ms,
		input logic                  repeat_flag,
		input logic [TAG_W-1:0]      task_tag
	);
		int unsigned kept;
		if (kind == KIND_CREATE) begin
			if (tasks_live >= TABLE_DEPTH) begin
				// Table full: nothing changes and the create is refused.
				events_due.push_back('{RES_ACK, task_tag, SLOT_W'(tasks_live), 1'b1, 1'b1});
			end else begin
				due_ms[tasks_live]    = now_ms + interval_ms;
				period_ms[tasks_live] = interval_ms;
				periodic[tasks_live]  = repeat_flag;
				owner_tag[tasks_live] = task_tag;
				events_due.push_back('{RES_ACK, task_tag, SLOT_W'(tasks_live), 1'b0, 1'b1});
				tasks_live++;
			end
			return;
		end
		// The scan covers every slot; slots above the live count are all zero.
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (due_ms[i] != '0 && due_ms[i] <= now_ms) begin
				events_due.push_back('{RES_FIRED, owner_tag[i], SLOT_W'(i), 1'b0, 1'b0});
				if (periodic[i])
					due_ms[i] = now_ms + period_ms[i];
				else
					due_ms[i] = '0;
			end
		end
		// Pack the survivors into the low slots in their original order; a
		// deadline that wrapped to zero counts as free and goes here.
		kept = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (due_ms[i] != '0) begin
				due_ms[kept]    = due_ms[i];
				period_ms[kept] = period_ms[i];
				periodic[kept]  = periodic[i];
				owner_tag[kept] = owner_tag[i];
				kept++;
			end
		end
		for (int i = kept; i < TABLE_DEPTH; i++) begin
			due_ms[i]    = '0;
			period_ms[i] = '0;
			periodic[i]  = 1'b0;
			owner_tag[i] = '0;
		end
		tasks_live = kept;
		events_due.push_back('{RES_DONE, '0, SLOT_W'(tasks_live), 1'b0, 1'b1});
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Drives one command at the falling edge and holds it until the block
	// takes the transfer. In bursty mode, valid is dropped for a random gap
	// at the end of each burst; in steady mode the next command follows at
	// once, so valid simply stays high.
	task automatic send_item(
		input item_kind_t            kind,
		input logic [TIME_W-1:0]     now_ms,
		input logic [INTERVAL_W-1:0] interval_ms,
		input logic                  repeat_flag,
		input logic [TAG_W-1:0]      task_tag
	);
		int unsigned gap;
		@(negedge clk);
		cmd_ch.valid       = 1'b1;
		cmd_ch.kind        = kind;
		cmd_ch.now_ms      = now_ms;
		cmd_ch.interval_ms = interval_ms;
		cmd_ch.repeat_flag = repeat_flag;
		cmd_ch.task_tag    = task_tag;
		@(posedge clk);
		while (cmd_ch.ready !== 1'b1)
			@(posedge clk);
		apply_timer_item(kind, now_ms, interval_ms, repeat_flag, task_tag);
		items_sent++;
		if (!steady_sender) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
				@(negedge clk);
				cmd_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
				burst_left = $urandom_range(0, 5);
			end
		end
	endtask

	// On a tick the create-only fields are don't-care, so they carry noise.
	task automatic tick_at(input logic [TIME_W-1:0] now_ms);
		send_item(KIND_TICK, now_ms, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic create_task(
		input logic [TIME_W-1:0]     now_ms,
		input logic [INTERVAL_W-1:0] interval_ms,
		input logic                  repeat_flag,
		input logic [TAG_W-1:0]      task_tag
	);
		send_item(KIND_CREATE, now_ms, interval_ms, repeat_flag, task_tag);
	endtask

	// Periodic tasks never free themselves unless a re-arm wraps to exactly
	// zero. A tick at the top of the time range fires everything and leaves
	// each periodic task due at period - 1; a tick at 2^32 - P then re-arms
	// every task of period P to zero. Repeating this empties the table of
	// periodic tasks with a non-zero period, and fires every one-shot task.
	task automatic retire_periodic_tasks();
		logic [INTERVAL_W-1:0] victim;
		bit                    found;
		tick_at('1);
		forever begin
			found = 1'b0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (!found && due_ms[i] != '0 && periodic[i] && period_ms[i] != '0) begin
					found  = 1'b1;
					victim = period_ms[i];
				end
			end
			if (!found)
				break;
			tick_at(32'h0 - {16'h0, victim});
			tick_at('1);
		end
	endtask

	// Field extremes on an empty table, a deadline that is zero on creation,
	// plain unsigned comparison at both ends of the time range, and
	// re-arms that wrap to exactly zero.
	task automatic test_field_extremes();
		create_task(32'd100, 16'h0000, 1'b0, 8'h00);
		create_task(32'd100, 16'hFFFF, 1'b1, 8'hFF);
		create_task(32'd100, 16'd5, 1'b1, 8'hA5);
		create_task(32'd0, 16'h0000, 1'b0, 8'h5A);
		create_task(32'hFFFF_FFFF, 16'd1, 1'b1, 8'h3C);
		// Nothing is due at time zero; the two zero deadlines simply vanish.
		tick_at(32'd0);
		tick_at(32'd105);
		tick_at(32'hFFFF_FFFF);
		// The period-5 task re-arms to zero here and is dropped.
		tick_at(32'hFFFF_FFFB);
		// And the 65535-period task goes the same way.
		tick_at(32'hFFFF_0001);
	endtask

	// Fill all sixteen slots, refuse one more create, then fire them all in
	// one tick, which gives the longest possible response sequence.
	task automatic test_table_full();
		for (int i = 0; i < TABLE_DEPTH; i++)
			create_task(32'h0000_1000, 16'(3 * i), 1'(i), 8'(17 * i));
		create_task(32'h0000_1000, 16'hFFFF, 1'b1, 8'hC3);
		tick_at(32'hFFFF_FFF0);
		retire_periodic_tasks();
	endtask

	// Mostly well-formed traffic: a random epoch, creates at the current
	// time with short intervals, and ticks that advance time by a few
	// milliseconds. Some epochs start just below the wrap point. The rest
	// is noise with every field random.
	task automatic test_random_traffic();
		int unsigned           goal;
		int unsigned           periodic_count;
		logic [TIME_W-1:0]     clock_ms;
		logic [INTERVAL_W-1:0] ivl;
		logic                  rep;
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			steady_sender = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					rep = 1'($urandom_range(0, 1));
					ivl = 16'($urandom_range(0, 65535));
					// A zero-period periodic task could never be removed.
					if (rep && ivl == '0)
						ivl = 16'd1;
					send_item(item_kind_t'($urandom_range(0, 1)), $urandom, ivl, rep,
						8'($urandom_range(0, 255)));
				end
			end else begin
				clock_ms = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 400)
					: $urandom;
				repeat ($urandom_range(6, 24)) begin
					if ($urandom_range(0, 9) < 4) begin
						tick_at(clock_ms);
						clock_ms += $urandom_range(1, 3);
					end else begin
						rep = ($urandom_range(0, 3) == 0);
						ivl = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
							: 16'($urandom_range(0, 24));
						if (rep && ivl == '0)
							ivl = 16'd1;
						create_task(clock_ms, ivl, rep, 8'($urandom_range(0, 255)));
					end
				end
			end
			periodic_count = 0;
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (due_ms[i] != '0 && periodic[i])
					periodic_count++;
			if (periodic_count >= 6 || (tasks_live >= TABLE_DEPTH && $urandom_range(0, 1) == 1))
				retire_periodic_tasks();
		end
	endtask

	// A periodic task with period zero re-arms at the current time and can
	// never leave the table, so it is only tried once, at the very end.
	task automatic test_zero_period_repeat();
		steady_sender = 1'b0;
		retire_periodic_tasks();
		create_task(32'd50, 16'h0000, 1'b1, 8'h77);
		tick_at(32'd50);
		tick_at(32'd49);
		tick_at(32'hFFFF_FFFF);
	endtask

	// Every accepted response transfer is compared with the oldest owed one.
	always @(posedge clk) begin : check_results
		timer_event_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (events_due.size() == 0) begin
				report_mismatch($sformatf("response with nothing owed: kind %0d tag %0d slot %0d",
					rsp_ch.result_kind, rsp_ch.fired_tag, rsp_ch.slot_index));
			end else begin
				want = events_due.pop_front();
				if (rsp_ch.result_kind !== want.kind)
					report_mismatch($sformatf("result_kind %0d, wanted %0d",
						rsp_ch.result_kind, want.kind));
				if (rsp_ch.fired_tag !== want.tag)
					report_mismatch($sformatf("fired_tag %0d, wanted %0d",
						rsp_ch.fired_tag, want.tag));
				if (rsp_ch.slot_index !== want.slot)
					report_mismatch($sformatf("slot_index %0d, wanted %0d",
						rsp_ch.slot_index, want.slot));
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("status %0d, wanted %0d",
						rsp_ch.status, want.status));
				if (rsp_ch.last !== want.last)
					report_mismatch($sformatf("last %0d, wanted %0d",
						rsp_ch.last, want.last));
			end
		end
	end

	// The receiver switches its manner from run to run: always ready, a
	// rotating 16-bit pattern that is never all stalls, a fair coin, or
	// mostly ready. Ready changes at the falling edge only.
	initial begin : response_stalls
		int unsigned      manner;
		logic [15:0]      pattern;
		rsp_ch.ready = 1'b0;
		forever begin
			manner  = $urandom_range(0, 3);
			pattern = 16'($urandom) | 16'h0001;
			for (int k = 0; k < 64; k++) begin
				@(negedge clk);
				case (manner)
					0: rsp_ch.ready = 1'b1;
					1: rsp_ch.ready = pattern[k % 16];
					2: rsp_ch.ready = 1'($urandom_range(0, 1));
					default: rsp_ch.ready = ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Ends the run if neither channel completes a transfer for too long.
	initial begin : watchdog
		int unsigned idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : run_tests
		cmd_ch.valid       = 1'b0;
		cmd_ch.kind        = KIND_CREATE;
		cmd_ch.now_ms      = '0;
		cmd_ch.interval_ms = '0;
		cmd_ch.repeat_flag = 1'b0;
		cmd_ch.task_tag    = '0;
		arst_n             = 1'b0;
		mismatches         = 0;
		items_sent         = 0;
		burst_left         = 0;
		steady_sender      = 1'b1;
		tasks_live         = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			due_ms[i]    = '0;
			period_ms[i] = '0;
			periodic[i]  = 1'b0;
			owner_tag[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_field_extremes();
		steady_sender = 1'b0;
		test_table_full();
		test_random_traffic();
		test_zero_period_repeat();

		@(negedge clk);
		cmd_ch.valid = 1'b0;
		// The watchdog bounds this wait if a response never turns up.
		while (events_due.size() != 0)
			@(posedge clk);
		// Any stray transfer after the last owed one is caught here.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && events_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
src/stt_pkg.sv
src/stt_if.sv
src/software_timer_task_table_top.sv
src/stt_checker.sv
tb/sv/tb.sv
